// ----- design/pedu_pkg.sv -----
// Shared types, constants and the hex digit helper for the percent-escape decoder.
`default_nettype none

package pedu_pkg;

    // Escape tracking state
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    localparam logic [7:0] PCT_CHAR  = 8'h25;
    localparam int         BURST_MAX = 3;

    typedef logic [1:0] count_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } result_t;

    typedef struct packed {
        count_t                      count;
        result_t [BURST_MAX-1:0]     ent;
    } burst_t;

    // Return {not_hex, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r = {1'b0, d[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            r = {1'b0, d[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            r = {1'b0, d[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/pedu_decode.sv -----
// Per-word decode: next escape state and the burst of results one input word causes.
`default_nettype none

module pedu_decode (
    input  wire pedu_pkg::phase_t phase,
    input  wire logic [7:0]       held,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    output pedu_pkg::phase_t      phase_next,
    output logic [7:0]            held_next,
    output pedu_pkg::burst_t      burst
);
    import pedu_pkg::*;

    logic [4:0] hi;
    logic [4:0] lo;

    assign hi = hex_value(held);
    assign lo = hex_value(in_byte);

    always_comb
    begin
        phase_next = PH_IDLE;
        held_next  = 8'h00;
        burst      = '0;
        case (phase)
            PH_PCT:
            begin
                if (in_last)
                begin
                    // string ends right after '%': flush both raw
                    burst.count  = 2'd2;
                    burst.ent[0] = '{data: PCT_CHAR, run_last: 1'b0, string_end: 1'b0};
                    burst.ent[1] = '{data: in_byte, run_last: 1'b1, string_end: 1'b1};
                end
                else
                begin
                    phase_next = PH_DIGIT;
                    held_next  = in_byte;
                end
            end
            PH_DIGIT:
            begin
                if (!hi[4] && !lo[4])
                begin
                    burst.count  = 2'd1;
                    burst.ent[0] = '{data: {hi[3:0], lo[3:0]}, run_last: 1'b1,
                                     string_end: in_last};
                end
                else
                begin
                    // not a valid escape: emit all three raw, no rescan
                    burst.count  = 2'd3;
                    burst.ent[0] = '{data: PCT_CHAR, run_last: 1'b0, string_end: 1'b0};
                    burst.ent[1] = '{data: held, run_last: 1'b0, string_end: 1'b0};
                    burst.ent[2] = '{data: in_byte, run_last: 1'b1, string_end: in_last};
                end
            end
            default:
            begin
                if (in_byte == PCT_CHAR && !in_last)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    burst.count  = 2'd1;
                    burst.ent[0] = '{data: in_byte, run_last: 1'b1, string_end: in_last};
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/pedu_burst.sv -----
// Result register: holds the burst from one input word and drains it one word per cycle while out_ready is high.
`default_nettype none

module pedu_burst (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire pedu_pkg::burst_t burst_in,
    input  wire logic             out_ready,
    output logic                  room,
    output logic                  out_valid,
    output pedu_pkg::result_t     head
);
    import pedu_pkg::*;

    count_t                  count_reg;
    count_t                  count_next;
    result_t [BURST_MAX-1:0] ent_reg;
    result_t [BURST_MAX-1:0] ent_next;

    assign out_valid = (count_reg != 2'd0);
    assign head      = ent_reg[0];
    // free next cycle if empty, or last entry leaves now
    assign room      = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);

    always_comb
    begin
        count_next = count_reg;
        ent_next   = ent_reg;
        if (load)
        begin
            count_next = burst_in.count;
            ent_next   = burst_in.ent;
        end
        else if (out_valid && out_ready)
        begin
            count_next  = count_reg - 2'd1;
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

// ----- design/percent_escape_decoder_unit.sv -----
// Top level of the percent-escape decoder: escape state, decode and result register.
`default_nettype none

// Percent-escape (URL) decoder. Feed the escaped string one byte per input
// word, with in_last set on its final byte. Plain bytes pass straight through;
// "%XY" with two hex digits becomes one byte 0xXY; an escape with a non-hex
// digit comes out as its three raw bytes, and an escape cut short by the end
// of the string comes out raw. Each output word carries run_last (final word
// caused by that input) and string_end (final byte of the decoded string).
// Rate: the block takes one input word per cycle while out_ready is high and
// each word causes at most one result; '%' and the first digit cause none. A
// word that causes two or three results holds in_ready low while the result
// register drains, since the output port moves at most one word per cycle.
// The first result appears in the cycle after the input is accepted. A new
// input is taken in the same cycle the last pending result leaves.

module percent_escape_decoder_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            string_end
);
    import pedu_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    burst_t     burst;
    result_t    head;
    logic       room;
    logic       in_fire;

    assign in_ready = room;
    assign in_fire  = in_valid && room;

    // Decode the incoming word against the open escape
    pedu_decode u_decode (
        .phase      (phase_reg),
        .held       (held_reg),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .phase_next (phase_next),
        .held_next  (held_next),
        .burst      (burst)
    );

    // Hold the results and hand them out one per cycle while out_ready is high
    pedu_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .burst_in  (burst),
        .out_ready (out_ready),
        .room      (room),
        .out_valid (out_valid),
        .head      (head)
    );

    assign out_byte   = head.data;
    assign run_last   = head.run_last;
    assign string_end = head.string_end;

    // Advance escape state only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the percent-escape decoder unit.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pedu_pkg::*;

    // Generous ceiling: at least 250 words, each with up to three results behind long
    // stalls on both sides, plus the long receiver hold-off, many times over.
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned WORD_TARGET = 250;
    localparam int unsigned HOLD_CYCLES = 100;

    // One input word waiting in the sender, with the idle cycles before it
    typedef struct {
        logic [7:0]  ch;
        logic        last;
        int unsigned gap;
    } src_word_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte    = 8'h00;
    logic       in_last    = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    src_word_t   pending_words[$];
    result_t     expected_chars[$];
    int unsigned words_total = 0;
    int unsigned words_taken = 0;
    int unsigned err_cnt     = 0;
    int unsigned cycle_cnt   = 0;
    logic        word_taken  = 1'b0;
    logic        hold_off    = 1'b0;
    int unsigned stall_left  = 0;

    // Decoder state as the scoreboard sees it
    phase_t     esc_phase = PH_IDLE;
    logic [7:0] held_char = 8'h00;

    percent_escape_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hex digit value in the low nibble, bit 4 set when the char is no digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]})
        begin
            v = {1'b0, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic rl, input logic se);
        expected_chars.push_back(result_t'{data: c, run_last: rl, string_end: se});
    endfunction

    // Advance the escape state by one accepted word and queue what it emits
    function automatic void decode_word(input logic [7:0] b, input logic last);
        logic [4:0] hi;
        logic [4:0] lo;
        case (esc_phase)
            PH_PCT:
            begin
                if (last)
                begin
                    // string cut short right after the '%': both go out raw
                    push_char(PCT_CHAR, 1'b0, 1'b0);
                    push_char(b, 1'b1, 1'b1);
                    esc_phase = PH_IDLE;
                    held_char = 8'h00;
                end
                else
                begin
                    held_char = b;
                    esc_phase = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                hi = nibble_of(held_char);
                lo = nibble_of(b);
                if (!hi[4] && !lo[4])
                begin
                    push_char({hi[3:0], lo[3:0]}, 1'b1, last);
                end
                else
                begin
                    // broken escape: emit all three raw, no rescan of b
                    push_char(PCT_CHAR, 1'b0, 1'b0);
                    push_char(held_char, 1'b0, 1'b0);
                    push_char(b, 1'b1, last);
                end
                esc_phase = PH_IDLE;
                held_char = 8'h00;
            end
            default:
            begin
                esc_phase = PH_IDLE;
                if (b == PCT_CHAR && !last)
                begin
                    esc_phase = PH_PCT;
                end
                else
                begin
                    push_char(b, 1'b1, last);
                end
            end
        endcase
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] hex_char();
        case ($urandom_range(0, 2))
            0:       return 8'h30 + 8'($urandom_range(0, 9));
            1:       return 8'h61 + 8'($urandom_range(0, 5));
            default: return 8'h41 + 8'($urandom_range(0, 5));
        endcase
    endfunction

    // Mostly non-digit chars, weighted toward the edges of the hex ranges
    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = 8'h2F;
            1:       c = 8'h3A;
            2:       c = 8'h40;
            3:       c = 8'h47;
            4:       c = 8'h60;
            5:       c = 8'h67;
            6:       c = PCT_CHAR;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic void add_word(input logic [7:0] c, input logic last,
                                     input int unsigned gap);
        pending_words.push_back(src_word_t'{ch: c, last: last, gap: gap});
        words_total++;
    endfunction

    // Build one random string: mostly well-formed escapes, some broken ones,
    // plain bytes in between, and sometimes an escape cut off by the end
    function automatic void add_random_string();
        logic [7:0]  chars[$];
        int unsigned segs;
        int unsigned r;
        logic        calm;
        segs = $urandom_range(1, 8);
        calm = ($urandom_range(0, 3) == 0);
        for (int unsigned s = 0; s < segs; s++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                chars.push_back(PCT_CHAR);
                chars.push_back(hex_char());
                chars.push_back(hex_char());
            end
            else if (r < 60)
            begin
                chars.push_back(PCT_CHAR);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        chars.push_back(non_hex_char());
                        chars.push_back(hex_char());
                    end
                    1:
                    begin
                        chars.push_back(hex_char());
                        chars.push_back(non_hex_char());
                    end
                    default:
                    begin
                        chars.push_back(non_hex_char());
                        chars.push_back(non_hex_char());
                    end
                endcase
            end
            else if (r < 65)
            begin
                chars.push_back(PCT_CHAR);
            end
            else
            begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            chars.push_back(PCT_CHAR);
        end
        else if (r < 25)
        begin
            chars.push_back(PCT_CHAR);
            chars.push_back(($urandom_range(0, 1) == 0) ? hex_char() : non_hex_char());
        end
        foreach (chars[i])
        begin
            add_word(chars[i], (i == chars.size() - 1), calm ? 0 : draw_gap());
        end
    endfunction

    // Sender: hold the word until taken, then idle or present the next one
    always @(negedge clk)
    begin
        logic       nv;
        logic [7:0] nb;
        logic       nl;
        src_word_t  w;
        nv = in_valid;
        nb = in_byte;
        nl = in_last;
        if (!rst_n)
        begin
            nv = 1'b0;
        end
        else if (!in_valid || word_taken)
        begin
            nv = 1'b0;
            nb = 8'($urandom_range(0, 255));
            nl = 1'($urandom_range(0, 1));
            if (pending_words.size() > 0)
            begin
                if (pending_words[0].gap > 0)
                begin
                    pending_words[0].gap--;
                end
                else
                begin
                    w  = pending_words.pop_front();
                    nv = 1'b1;
                    nb = w.ch;
                    nl = w.last;
                end
            end
        end
        in_valid <= nv;
        in_byte  <= nb;
        in_last  <= nl;
    end

    // Receiver: random stalls, no new stalls in every third stretch of the run,
    // and nothing at all while the long hold-off runs
    always @(negedge clk)
    begin
        logic rdy;
        rdy = 1'b0;
        if (rst_n && !hold_off)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else
            begin
                rdy = 1'b1;
                if ((cycle_cnt / 300) % 3 != 1)
                begin
                    stall_left = draw_gap();
                end
            end
        end
        out_ready <= rdy;
    end

    // Long hold-off: the sender keeps offering words, so the result register
    // fills and the block has to drop in_ready
    initial
    begin
        wait (words_taken >= 120);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off <= 1'b0;
    end

    // Monitor: check the output word first, then predict from the input word
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected output word: out_byte %h run_last %b string_end %b",
                       out_byte, run_last, string_end);
                err_cnt++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %h, got %h", want.data, out_byte);
                    err_cnt++;
                end
                if (run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, run_last);
                    err_cnt++;
                end
                if (string_end !== want.string_end)
                begin
                    $error("string_end: expected %b, got %b", want.string_end, string_end);
                    err_cnt++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            decode_word(in_byte, in_last);
            words_taken++;
        end
        word_taken <= rst_n && in_valid && in_ready;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        // A two-byte string holding both ends of the byte range
        add_word(8'h00, 1'b0, 0);
        add_word(8'hFF, 1'b1, 0);
        // Well-formed escapes, the second one closing its string
        add_word(PCT_CHAR, 1'b0, 0);
        add_word("4", 1'b0, 0);
        add_word("1", 1'b0, 0);
        add_word(PCT_CHAR, 1'b0, 0);
        add_word("f", 1'b0, 1);
        add_word("F", 1'b1, 0);
        // '%' as the final byte of a string
        add_word(PCT_CHAR, 1'b1, 0);
        // String ends right after '%'
        add_word(PCT_CHAR, 1'b0, 0);
        add_word(8'h80, 1'b1, 0);
        // Non-hex first digit, then a '%' in third place that must not reopen
        add_word(PCT_CHAR, 1'b0, 0);
        add_word("z", 1'b0, 0);
        add_word(PCT_CHAR, 1'b0, 0);
        add_word("4", 1'b0, 0);
        add_word("1", 1'b1, 0);
        // High bytes are never digits, in either position
        add_word(PCT_CHAR, 1'b0, 2);
        add_word("9", 1'b0, 0);
        add_word(8'h80, 1'b0, 0);
        add_word(PCT_CHAR, 1'b0, 0);
        add_word(8'hC6, 1'b0, 0);
        add_word("0", 1'b1, 0);

        while (words_total < WORD_TARGET)
        begin
            add_random_string();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken < words_total)
        begin
            @(posedge clk);
        end
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        // Catch any stray word the block might still put out
        repeat (10) @(posedge clk);

        if (err_cnt == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/pedu_pkg.sv
design/pedu_decode.sv
design/pedu_burst.sv
design/percent_escape_decoder_unit.sv
dv/tb.sv
